FILE: hw/rtl/min_swaps_to_sort_core_defines.svh
// Assertion macros for the min-swaps core.
`ifndef MIN_SWAPS_TO_SORT_CORE_DEFINES_SVH
`define MIN_SWAPS_TO_SORT_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MSS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define MSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define MSS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/mss_pkg.sv
package mss_pkg;
	localparam int MaxItems   = 256;
	localparam int ValueWidth = 32;
	localparam int IdxW       = $clog2(MaxItems);
	localparam int CntW       = $clog2(MaxItems + 1);
	localparam int SwapW      = 8;
	typedef logic [IdxW-1:0] idx_t;
	typedef logic [CntW-1:0] cnt_t;
	typedef logic [ValueWidth-1:0] key_t;

	function automatic key_t order_key(input logic [ValueWidth-1:0] raw);
		order_key = {~raw[ValueWidth-1], raw[ValueWidth-2:0]};
	endfunction
endpackage

FILE: hw/rtl/mss_ranker.sv
// Stable rank of each stored key: for every i, one sweep over j reading the key memory.
module mss_ranker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  mss_pkg::cnt_t n,
	output logic          busy,
	output logic          done,
	input  logic          wr_en,
	input  mss_pkg::idx_t wr_addr,
	input  mss_pkg::key_t wr_key,
	output logic          pos_we,
	output mss_pkg::idx_t pos_addr,
	output mss_pkg::idx_t pos_data
);
	import mss_pkg::*;

	key_t key_mem [MaxItems];
	key_t rd_key;
	key_t ki_q;
	cnt_t i_q, j_q, rank_q;
	idx_t rd_addr;
	logic [1:0] st_q;
	logic vld_s1;
	idx_t j_s1;
	cnt_t jn;
	logic less;

	localparam logic [1:0] S_IDLE = 2'd0, S_LOADI = 2'd1, S_WAITI = 2'd2, S_SCAN = 2'd3;

	always_ff @(posedge clk) begin
		if (wr_en) key_mem[wr_addr] <= wr_key;
		rd_key <= key_mem[rd_addr];
	end

	always_comb begin
		rd_addr = j_q[IdxW-1:0];
		if (st_q == S_LOADI) rd_addr = i_q[IdxW-1:0];
	end

	assign less = (rd_key < ki_q) || (rd_key == ki_q && cnt_t'(j_s1) < i_q);
	assign jn = j_q + cnt_t'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			vld_s1 <= 1'b0;
			done <= 1'b0;
			pos_we <= 1'b0;
		end else begin
			done <= 1'b0;
			pos_we <= 1'b0;
			vld_s1 <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (start) begin
						i_q <= '0;
						if (n == '0) done <= 1'b1;
						else st_q <= S_LOADI;
					end
				end
				S_LOADI: st_q <= S_WAITI;
				S_WAITI: begin
					ki_q <= rd_key;
					j_q <= '0;
					rank_q <= '0;
					st_q <= S_SCAN;
				end
				S_SCAN: begin
					if (vld_s1 && less) rank_q <= rank_q + cnt_t'(1);
					if (j_q < n) begin
						vld_s1 <= 1'b1;
						j_s1 <= j_q[IdxW-1:0];
						j_q <= jn;
					end else if (!vld_s1) begin
						pos_we <= 1'b1;
						pos_addr <= i_q[IdxW-1:0];
						pos_data <= rank_q[IdxW-1:0];
						i_q <= i_q + cnt_t'(1);
						if (i_q + cnt_t'(1) == n) begin
							done <= 1'b1;
							st_q <= S_IDLE;
						end else st_q <= S_LOADI;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (st_q != S_IDLE);
endmodule

FILE: hw/rtl/min_swaps_to_sort_core.sv
// Minimum swaps to sort a batch. Values stream in, one per accepted transaction, at up to
// one per cycle. The transaction with last_item starts ranking: each of the n stored items
// is ranked in turn by a full sweep of the key memory (single read port of that memory).
// The visited marks of the first n entries are cleared during ranking. A cycle walk over
// the rank and mark memories follows: it checks the mark of each index and then follows
// each unvisited element's cycle through the rank memory. One result per batch, held in
// an output register until taken. Up to 256 items are stored; extra items are dropped and
// flagged by overflow. Input stalls while a batch is being counted and while its result
// waits for a previous one still held at the output.
module min_swaps_to_sort_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  valid_in,
	output logic                                  stall_in,
	input  logic signed [mss_pkg::ValueWidth-1:0] value,
	input  logic                                  last_item,
	output logic                                  valid_out,
	input  logic                                  stall_out,
	output logic [mss_pkg::SwapW-1:0]             swap_count,
	output logic                                  overflow
);
	import mss_pkg::*;

	localparam logic [2:0] C_FILL = 3'd0, C_RANK = 3'd1, C_SEEK = 3'd2,
		C_RD = 3'd3, C_STEP = 3'd4, C_OUT = 3'd5, C_CHK = 3'd6;

	logic [2:0] st_q;
	cnt_t cnt_q;
	logic ovf_q;
	logic acc;
	logic store;
	logic rk_start, rk_busy, rk_done;
	logic pos_we;
	idx_t pos_addr, pos_data;
	idx_t pos_mem [MaxItems];
	idx_t pos_rd;
	idx_t pos_ra;
	logic vis_mem [MaxItems];
	logic vis_rd;
	logic vis_we;
	logic vis_wd;
	idx_t vis_wa;
	cnt_t clr_q;
	cnt_t i_q, cyc_q;
	idx_t p_q;
	cnt_t swaps;
	logic out_load;

	assign acc = valid_in && !stall_in;
	assign stall_in = (st_q != C_FILL);
	assign store = acc && (cnt_q < cnt_t'(MaxItems));
	assign rk_start = acc && last_item;

	mss_ranker u_rank (
		.clk(clk), .arst_n(arst_n), .start(rk_start),
		.n(store ? cnt_q + cnt_t'(1) : cnt_q),
		.busy(rk_busy), .done(rk_done),
		.wr_en(store), .wr_addr(cnt_q[IdxW-1:0]),
		.wr_key(order_key(value)),
		.pos_we(pos_we), .pos_addr(pos_addr), .pos_data(pos_data)
	);

	always_ff @(posedge clk) begin
		if (pos_we) pos_mem[pos_addr] <= pos_data;
		pos_rd <= pos_mem[pos_ra];
	end
	assign pos_ra = p_q;

	// marks: cleared over the batch while ranking, set once per element during the walk
	always_comb begin
		vis_we = 1'b0;
		vis_wa = i_q[IdxW-1:0];
		vis_wd = 1'b1;
		case (st_q)
			C_RANK: begin
				if (clr_q < cnt_q) begin
					vis_we = 1'b1;
					vis_wa = clr_q[IdxW-1:0];
					vis_wd = 1'b0;
				end
			end
			C_CHK: begin
				if (!vis_rd) vis_we = 1'b1;
			end
			C_STEP: begin
				if (pos_rd != i_q[IdxW-1:0]) begin
					vis_we = 1'b1;
					vis_wa = pos_rd;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (vis_we) vis_mem[vis_wa] <= vis_wd;
		vis_rd <= vis_mem[i_q[IdxW-1:0]];
	end

	assign swaps = cnt_q - cyc_q;
	assign out_load = (st_q == C_OUT) && (!valid_out || !stall_out);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (out_load) begin
			valid_out <= 1'b1;
		end else if (!stall_out) begin
			valid_out <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= C_FILL;
			cnt_q <= '0;
			ovf_q <= 1'b0;
			clr_q <= '0;
		end else begin
			case (st_q)
				C_FILL: begin
					if (acc) begin
						if (store) cnt_q <= cnt_q + cnt_t'(1);
						else ovf_q <= 1'b1;
						if (last_item) begin
							clr_q <= '0;
							st_q <= C_RANK;
						end
					end
				end
				C_RANK: begin
					if (clr_q < cnt_q) clr_q <= clr_q + cnt_t'(1);
					if (rk_done) begin
						i_q <= '0;
						cyc_q <= '0;
						st_q <= C_SEEK;
					end
				end
				C_SEEK: begin
					if (i_q == cnt_q) st_q <= C_OUT;
					else st_q <= C_CHK;
				end
				C_CHK: begin
					if (vis_rd) begin
						i_q <= i_q + cnt_t'(1);
						st_q <= C_SEEK;
					end else begin
						cyc_q <= cyc_q + cnt_t'(1);
						p_q <= i_q[IdxW-1:0];
						st_q <= C_RD;
					end
				end
				C_RD: st_q <= C_STEP;
				C_STEP: begin
					// an unvisited start always closes its own cycle
					if (pos_rd == i_q[IdxW-1:0]) begin
						i_q <= i_q + cnt_t'(1);
						st_q <= C_SEEK;
					end else begin
						p_q <= pos_rd;
						st_q <= C_RD;
					end
				end
				C_OUT: begin
					if (out_load) begin
						swap_count <= (swaps > cnt_t'(255)) ? {SwapW{1'b1}} : swaps[SwapW-1:0];
						overflow <= ovf_q;
						cnt_q <= '0;
						ovf_q <= 1'b0;
						st_q <= C_FILL;
					end
				end
				default: st_q <= C_FILL;
			endcase
		end
	end

	`include "min_swaps_to_sort_core_defines.svh"
	`MSS_ASSERT_IMPL(a_no_accept_busy, clk, arst_n, rk_busy, !acc)
	`MSS_ASSERT_IMPL(a_cyc_le_cnt, clk, arst_n, st_q == C_SEEK, cyc_q <= cnt_q)
	`MSS_ASSERT_NEXT(a_last_ranks, clk, arst_n, rk_start, st_q == C_RANK)
	`MSS_ASSERT_IMPL(a_clr_done, clk, arst_n, st_q == C_RANK && rk_done, clr_q == cnt_q)
endmodule

FILE: tb/min_swaps_to_sort_core_test.sv
`timescale 1ns / 100ps

module min_swaps_to_sort_core_test;
	import mss_pkg::*;

	typedef struct {
		logic signed [31:0] value;
		logic               last_item;
	} elem_t;

	typedef struct {
		logic [7:0] swap_count;
		logic       overflow;
	} swap_result_t;

	logic               clk;
	logic               arst_n;
	logic               valid_in;
	logic               stall_in;
	logic signed [31:0] value;
	logic               last_item;
	logic               valid_out;
	logic               stall_out;
	logic [7:0]         swap_count;
	logic               overflow;

	elem_t        pending_elems[$];
	swap_result_t expected_counts[$];

	// predictor state
	logic [31:0] batch_keys[MaxItems];
	int          batch_len;
	logic        batch_dropped;

	int  fail_count;
	int  idle_cycles;
	int  in_wait;
	int  out_wait;

	// handshake state seen at the last rising edge
	logic stall_in_q;
	logic out_taken_q;

	min_swaps_to_sort_core uut (
		.clk(clk), .arst_n(arst_n),
		.valid_in(valid_in), .stall_in(stall_in),
		.value(value), .last_item(last_item),
		.valid_out(valid_out), .stall_out(stall_out),
		.swap_count(swap_count), .overflow(overflow)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// stable ascending rank, then swaps = n - number of permutation cycles
	function automatic swap_result_t count_swaps();
		int          dest[MaxItems];
		bit          seen[MaxItems];
		int          r;
		int          p;
		int          cycles;
		swap_result_t res;
		cycles = 0;
		for (int i = 0; i < batch_len; i++) begin
			r = 0;
			for (int j = 0; j < batch_len; j++)
				if (batch_keys[j] < batch_keys[i] || (batch_keys[j] == batch_keys[i] && j < i))
					r++;
			dest[i] = r;
			seen[i] = 1'b0;
		end
		for (int i = 0; i < batch_len; i++) begin
			if (!seen[i]) begin
				cycles++;
				p = i;
				while (!seen[p]) begin
					seen[p] = 1'b1;
					p = dest[p];
				end
			end
		end
		r = batch_len - cycles;
		res.swap_count = (r > 255) ? 8'd255 : r[7:0];
		res.overflow = batch_dropped;
		return res;
	endfunction

	function automatic void predict_elem(elem_t e);
		if (batch_len < MaxItems) begin
			batch_keys[batch_len] = {~e.value[31], e.value[30:0]};
			batch_len++;
		end else begin
			batch_dropped = 1'b1;
		end
		if (e.last_item) begin
			expected_counts.push_back(count_swaps());
			batch_len = 0;
			batch_dropped = 1'b0;
		end
	endfunction

	function automatic logic signed [31:0] rand_value(int mode);
		case (mode)
			0: return $urandom();
			1: return $signed($urandom_range(0, 15)) - 8;
			2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: return $signed($urandom_range(0, 2000)) - 1000;
		endcase
	endfunction

	task automatic add_batch(int len, int mode);
		elem_t e;
		for (int i = 0; i < len; i++) begin
			e.value = rand_value(mode);
			e.last_item = (i == len - 1);
			pending_elems.push_back(e);
		end
	endtask

	task automatic add_list(logic signed [31:0] vals[$]);
		elem_t e;
		foreach (vals[i]) begin
			e.value = vals[i];
			e.last_item = (i == vals.size() - 1);
			pending_elems.push_back(e);
		end
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (valid_in && !stall_in_q) begin
				valid_in <= 1'b0;
				in_wait <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
			end else if (!valid_in) begin
				if (in_wait > 0) begin
					in_wait <= in_wait - 1;
				end else if (pending_elems.size() > 0) begin
					elem_t e;
					e = pending_elems.pop_front();
					value <= e.value;
					last_item <= e.last_item;
					valid_in <= 1'b1;
				end
			end
		end
	end

	// stall seen at the last rising edge decides whether the transaction went through
	always @(posedge clk) begin
		stall_in_q <= stall_in;
		out_taken_q <= arst_n && valid_out && !stall_out;
		if (arst_n && valid_in && !stall_in) begin
			elem_t e;
			e.value = value;
			e.last_item = last_item;
			predict_elem(e);
		end
	end

	// output side stall pattern: a fresh wait after each result taken
	always @(negedge clk) begin
		int w;
		if (arst_n) begin
			if (out_taken_q) begin
				w = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
				stall_out <= (w > 0);
				out_wait <= (w > 0) ? w - 1 : 0;
			end else if (out_wait > 0) begin
				out_wait <= out_wait - 1;
				stall_out <= 1'b1;
			end else begin
				stall_out <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if ((valid_in && !stall_in) || (valid_out && !stall_out))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (valid_out && !stall_out) begin
				swap_result_t exp_r;
				if (expected_counts.size() == 0) begin
					$display("%0t: unexpected result swap_count=%0d overflow=%0d",
						$time, swap_count, overflow);
					fail_count++;
				end else begin
					exp_r = expected_counts.pop_front();
					if (swap_count !== exp_r.swap_count) begin
						$display("%0t: swap_count expected %0d actual %0d",
							$time, exp_r.swap_count, swap_count);
						fail_count++;
					end
					if (overflow !== exp_r.overflow) begin
						$display("%0t: overflow expected %0d actual %0d",
							$time, exp_r.overflow, overflow);
						fail_count++;
					end
				end
			end
		end
	end

	// watchdog: a full 256-entry batch must finish ranking before the idle limit is reached
	always @(posedge clk) begin
		if (idle_cycles > 400000) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int total;
		int len;
		arst_n = 1'b0;
		valid_in = 1'b0;
		value = '0;
		last_item = 1'b0;
		stall_out = 1'b0;
		stall_in_q = 1'b1;
		out_taken_q = 1'b0;
		batch_len = 0;
		batch_dropped = 1'b0;
		fail_count = 0;
		idle_cycles = 0;
		in_wait = 0;
		out_wait = 0;

		// directed: single item, extremes, sorted, reversed, duplicates
		add_list('{32'sh7fffffff});
		add_list('{32'sh80000000, 32'sh7fffffff});
		add_list('{32'sh7fffffff, 32'sh80000000});
		add_list('{32'sh0, -32'sd1, 32'sh7fffffff, 32'sh80000000, 32'sd1});
		add_list('{32'sd5, 32'sd5, 32'sd5, 32'sd5});
		add_list('{32'sd3, 32'sd1, 32'sd3, 32'sd1});
		add_list('{32'shffffffff, 32'sh55555555, 32'shaaaaaaaa, 32'sh0});
		// exactly full batch, then one item too many with the last one dropped
		add_batch(256, 0);
		add_batch(257, 3);

		total = 0;
		while (total < 215) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
			add_batch(len, $urandom_range(0, 3));
			total += len;
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_elems.size() == 0 && !valid_in);
		wait (expected_counts.size() == 0);
		repeat (300) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
